// ----- src/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// No dependencies; imported by every module of the block.
package bole_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 7;
  localparam int FIDX_W       = 6;
  localparam int CNT_OUT_W    = 7;
  localparam int CAPACITY_DEF = 64;
  // match bits per first-level group of the search encoder
  localparam int GRP_W        = 8;
  localparam int GIDX_W       = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT     = 3'd2,
    MODE_DELETE     = 3'd3,
    MODE_POP_FRONT  = 3'd4,
    MODE_POP_BACK   = 3'd5,
    MODE_SEARCH     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_FINISH
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- src/bole_cell.sv -----
// One list slot of the cell chain: holds an entry, shifts to/from neighbors.
// Depends on bole_pkg.
module bole_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6
) (
  input  logic                              clk,
  input  bole_pkg::cell_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]                  idx,
  input  logic signed [bole_pkg::DATA_W-1:0] left_data,
  input  logic signed [bole_pkg::DATA_W-1:0] right_data,
  output logic signed [bole_pkg::DATA_W-1:0] data,
  output logic                              match
);
  import bole_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (MY_IDX > idx) begin
        data_nxt = left_data;
      end else if (MY_IDX == idx) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == ctrl.value);

endmodule

// ----- src/bole_genc.sv -----
// First-match encoder over one group of search match bits.
// Depends on bole_pkg.
module bole_genc (
  input  logic [bole_pkg::GRP_W-1:0]  bits,
  output logic                        any,
  output logic [bole_pkg::GIDX_W-1:0] idx
);
  import bole_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = GIDX_W'(i);
      end
    end
  end

  assign any = |bits;

endmodule

// ----- src/bounded_ordered_list_engine.sv -----
// Bounded ordered list engine: ordered list of signed 32-bit entries in a cell chain.
// Push/insert/delete/pop and empty-list search: result in the cycle after acceptance.
// Throughput: one request per cycle while busy is low; a non-empty search holds busy
// while the registered two-level first-match encoder resolves the index.
// Reset (rst_n low, synchronous): count cleared, FSM idle, no result pending;
// entries are not cleared. Results are strobed for one cycle; the receiver cannot stall.
module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bole_pkg::MODE_W-1:0]          in_mode,
  input  logic [bole_pkg::POS_W-1:0]           in_position,
  input  logic signed [bole_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic                                 out_found,
  output logic [bole_pkg::FIDX_W-1:0]          out_found_index,
  output logic [bole_pkg::CNT_OUT_W-1:0]       out_entry_count
);
  import bole_pkg::*;

  // count needs to reach CAPACITY; an index only CAPACITY-1
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
  localparam int NG     = (CAPACITY + GRP_W - 1) / GRP_W;
  localparam int GSEL_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int FW     = GSEL_W + GIDX_W;

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  logic             accept;
  logic             search_go;   // search on a non-empty list: run the encoder
  logic             grp_load;
  logic             fin;

  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // Request decode: status, shift direction and slot index
  // ---------------------------------------------------------------
  mode_t            mode;
  status_t          req_status;
  cell_ctrl_t       ctrl;
  logic [IW-1:0]    req_idx;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             is_full;
  logic             is_empty;

  assign mode     = mode_t'(in_mode);
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign is_full  = (cnt_ext >= CMP_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    req_status = STATUS_OK;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.value = in_value;
    req_idx    = '0;
    search_go  = 1'b0;
    count_nxt  = count_r;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        req_idx = (mode == MODE_PUSH_FRONT) ? '0 : IW'(count_r);
        if (is_full) begin
          req_status = STATUS_FULL;
        end else begin
          ctrl.ins = accept;
        end
      end
      MODE_INSERT: begin
        req_idx = IW'(in_position);
        if (pos_ext > cnt_ext) begin
          req_status = STATUS_RANGE;
        end else if (is_full) begin
          req_status = STATUS_FULL;
        end else begin
          ctrl.ins = accept;
        end
      end
      MODE_DELETE: begin
        req_idx = IW'(in_position);
        if (pos_ext >= cnt_ext) begin
          req_status = STATUS_RANGE;
        end else begin
          ctrl.del = accept;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        req_idx = (mode == MODE_POP_FRONT) ? '0 : IW'(count_r - 1'b1);
        if (is_empty) begin
          req_status = STATUS_EMPTY;
        end else begin
          ctrl.del = accept;
        end
      end
      MODE_SEARCH: begin
        if (is_empty) begin
          req_status = STATUS_EMPTY;
        end else begin
          search_go = 1'b1;
        end
      end
      default: begin
        // unused code: no change, status ok
      end
    endcase
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.del) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Cell chain: one cell per slot, shifting right on insert, left on delete
  // ---------------------------------------------------------------
  logic signed [DATA_W-1:0] cell_data  [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    bole_cell #(
      .INDEX (i),
      .IDX_W (IW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (req_idx),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  // ---------------------------------------------------------------
  // Search: match bits (only live slots) -> group encode -> final pick
  // ---------------------------------------------------------------
  logic [CAPACITY-1:0]   match_r;
  logic [CAPACITY-1:0]   live;
  logic [NG*GRP_W-1:0]   match_pad;
  logic [NG-1:0]         grp_any, grp_any_r;
  logic [GIDX_W-1:0]     grp_idx   [NG];
  logic [GIDX_W-1:0]     grp_idx_r [NG];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_live
    assign live[i] = (count_r > CW'(i));
  end

  always_ff @(posedge clk) begin
    if (accept && search_go) begin
      match_r <= cell_match & live;
    end
  end

  assign match_pad = (NG*GRP_W)'(match_r);

  for (genvar g = 0; g < NG; g++) begin : g_grp
    bole_genc u_genc (
      .bits (match_pad[g*GRP_W +: GRP_W]),
      .any  (grp_any[g]),
      .idx  (grp_idx[g])
    );
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_any_r <= grp_any;
      grp_idx_r <= grp_idx;
    end
  end

  logic          fin_found;
  logic [FW-1:0] fin_idx;

  always_comb begin
    fin_found = 1'b0;
    fin_idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        fin_found = 1'b1;
        fin_idx   = FW'(g * GRP_W) + FW'(grp_idx_r[g]);
      end
    end
  end

  // ---------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && search_go) state_nxt = ST_GROUP;
      ST_GROUP:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    grp_load = 1'b0;
    fin      = 1'b0;
    case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_GROUP: begin
        busy     = 1'b1;
        grp_load = 1'b1;
      end
      ST_FINISH: begin
        busy = 1'b1;
        fin  = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [FIDX_W-1:0]    out_fidx_r, out_fidx_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_fidx_nxt   = out_fidx_r;
    out_cnt_nxt    = out_cnt_r;
    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_found_nxt  = fin_found;
      out_fidx_nxt   = FIDX_W'(fin_idx);
      out_cnt_nxt    = CNT_OUT_W'(count_r);
    end else if (accept && !search_go) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = req_status;
      out_found_nxt  = 1'b0;
      out_fidx_nxt   = '0;
      out_cnt_nxt    = CNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_fidx_r;
  assign out_entry_count = out_cnt_r;

endmodule

// ----- src/bole_chk.sv -----
// Port-level checker for bounded_ordered_list_engine, with its bind.
// Depends on bole_pkg.
module bole_chk #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic [1:0]                           out_status,
  input logic                                 out_found,
  input logic [bole_pkg::CNT_OUT_W-1:0]       out_entry_count
);
  import bole_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CAP_LOW = CNT_OUT_W'(CAPACITY);

  // every accepted request either answers next cycle or starts a search
  a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted request neither answered nor busy");

  // a search ending releases busy together with its result
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == STATUS_OK)
    else $error("found with non-ok status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_entry_count == CAP_LOW)
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_entry_count == '0 && !out_found)
    else $error("empty status with nonzero count");

endmodule

bind bounded_ordered_list_engine bole_chk #(.CAPACITY(CAPACITY)) u_bole_chk (.*);

// ----- tb/sv/testbench.sv -----
// Testbench for bounded_ordered_list_engine: directed and random list requests,
// with results checked against a shadow copy of the list. Depends on bole_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import bole_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT  = 1000;  // cycles with no request and no result accepted
  // code outside the operation set: the block leaves the list alone
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // Expected outcome of one request.
  typedef struct {
    status_t               status;
    bit                    found;
    bit [FIDX_W-1:0]       found_index;
    bit [CNT_OUT_W-1:0]    entry_count;
  } list_outcome_t;

  // Shadow list plus the outcomes still owed by the block.
  class list_scoreboard;
    logic signed [DATA_W-1:0] shadow_list[$];
    list_outcome_t            owed_outcomes[$];
    int                       errors;
    int                       results_checked;
    int                       search_hits;
    int                       mode_seen[8];
    int                       status_seen[4];

    function int entry_total();
      return shadow_list.size();
    endfunction

    function int pending();
      return owed_outcomes.size();
    endfunction

    // Applies one accepted request to the shadow list and queues its outcome.
    function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_outcome_t o;
      int            n;
      n = shadow_list.size();
      o.status      = STATUS_OK;
      o.found       = 1'b0;
      o.found_index = '0;
      case (mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (n >= LIST_DEPTH) o.status = STATUS_FULL;
          else if (mode == MODE_PUSH_FRONT) shadow_list.push_front(val);
          else shadow_list.push_back(val);
        end
        MODE_INSERT: begin
          // range check wins over the full check
          if (pos > n) o.status = STATUS_RANGE;
          else if (n >= LIST_DEPTH) o.status = STATUS_FULL;
          else shadow_list.insert(pos, val);
        end
        MODE_DELETE: begin
          if (pos >= n) o.status = STATUS_RANGE;
          else shadow_list.delete(pos);
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (n == 0) o.status = STATUS_EMPTY;
          else if (mode == MODE_POP_FRONT) void'(shadow_list.pop_front());
          else void'(shadow_list.pop_back());
        end
        MODE_SEARCH: begin
          if (n == 0) o.status = STATUS_EMPTY;
          else begin
            for (int k = 0; k < n && !o.found; k++) begin
              if (shadow_list[k] == val) begin
                o.found       = 1'b1;
                o.found_index = k[FIDX_W-1:0];
              end
            end
          end
          if (o.found) search_hits++;
        end
        default: ;
      endcase
      o.entry_count = CNT_OUT_W'(shadow_list.size());
      mode_seen[mode]++;
      status_seen[o.status]++;
      owed_outcomes.push_back(o);
    endfunction

    // Compares one strobed result with the oldest owed outcome.
    function void check_result(logic [1:0] status, logic found,
                               logic [FIDX_W-1:0] fidx, logic [CNT_OUT_W-1:0] cnt);
      list_outcome_t o;
      if (owed_outcomes.size() == 0) begin
        $display("%0t: result with none expected: status %0d found %0d index %0d count %0d",
                 $time, status, found, fidx, cnt);
        errors++;
        return;
      end
      o = owed_outcomes.pop_front();
      results_checked++;
      if (status !== o.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, status);
        errors++;
      end
      if (found !== o.found) begin
        $display("%0t: found mismatch: expected %0d actual %0d", $time, o.found, found);
        errors++;
      end
      if (fidx !== o.found_index) begin
        $display("%0t: found_index mismatch: expected %0d actual %0d",
                 $time, o.found_index, fidx);
        errors++;
      end
      if (cnt !== o.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                 $time, o.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode;
  logic [POS_W-1:0]          in_position;
  logic signed [DATA_W-1:0]  in_value;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic                      out_found;
  logic [FIDX_W-1:0]         out_found_index;
  logic [CNT_OUT_W-1:0]      out_entry_count;

  list_scoreboard sb = new();
  int             stall_cycles = 0;

  bounded_ordered_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_found_index(out_found_index),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_status, out_found, out_found_index, out_entry_count);
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL bounded_ordered_list_engine");
      $finish;
    end
  end

  // Drives one request and waits for the edge that accepts it. Optional idle
  // cycles come first; they fall on whatever phase the block is in, including
  // the busy cycles of a search.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input bit allow_gaps);
    while (allow_gaps && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(mode, pos, val);
  endtask

  // Values: a narrow pool so lists hold duplicates and searches hit,
  // the extremes, and fully random words.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return DATA_W'($signed($urandom_range(8)) - 4);
    if (r < 50) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Operation mix: a growing phase favors pushes and inserts so the list
  // reaches full; a shrinking phase favors deletes and pops down to empty.
  function automatic logic [MODE_W-1:0] pick_mode(bit grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 25) return MODE_PUSH_FRONT;
      if (r < 50) return MODE_PUSH_BACK;
      if (r < 72) return MODE_INSERT;
      if (r < 82) return MODE_SEARCH;
      if (r < 88) return MODE_DELETE;
      if (r < 93) return MODE_POP_FRONT;
      if (r < 98) return MODE_POP_BACK;
    end else begin
      if (r < 6)  return MODE_PUSH_FRONT;
      if (r < 12) return MODE_PUSH_BACK;
      if (r < 18) return MODE_INSERT;
      if (r < 30) return MODE_SEARCH;
      if (r < 55) return MODE_DELETE;
      if (r < 75) return MODE_POP_FRONT;
      if (r < 97) return MODE_POP_BACK;
    end
    return MODE_UNUSED;  // no change expected
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                grow;
    int                n;
    int                r;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_mode     <= '0;
    in_position <= '0;
    in_value    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases first, then extremes and edges.
    send_request(MODE_SEARCH,     7'd0,   32'h0000_0000, 1'b1);  // search, empty
    send_request(MODE_POP_FRONT,  7'd0,   32'h0000_0000, 1'b1);  // pop, empty
    send_request(MODE_POP_BACK,   7'd0,   32'h0000_0000, 1'b1);
    send_request(MODE_DELETE,     7'd0,   32'h0000_0000, 1'b1);  // delete, empty
    send_request(MODE_INSERT,     7'd1,   32'h0000_0001, 1'b1);  // insert past end
    send_request(MODE_INSERT,     7'd127, 32'h0000_0001, 1'b1);
    send_request(MODE_INSERT,     7'd0,   32'h8000_0000, 1'b1);  // most negative
    send_request(MODE_PUSH_BACK,  7'd0,   32'h7FFF_FFFF, 1'b1);  // most positive
    send_request(MODE_PUSH_FRONT, 7'd0,   32'hFFFF_FFFF, 1'b1);
    send_request(MODE_PUSH_BACK,  7'd0,   32'h0000_0000, 1'b1);
    send_request(MODE_INSERT,     7'd4,   32'h0000_0005, 1'b1);  // insert at end
    send_request(MODE_INSERT,     7'd2,   32'hFFFF_FFFF, 1'b1);  // duplicate value
    send_request(MODE_SEARCH,     7'd0,   32'hFFFF_FFFF, 1'b1);  // first of two matches
    send_request(MODE_SEARCH,     7'd0,   32'h0000_0005, 1'b1);  // match at last entry
    send_request(MODE_SEARCH,     7'd0,   32'h0000_3039, 1'b1);  // no match
    send_request(MODE_DELETE,     7'd6,   32'h0000_0000, 1'b1);  // delete at count
    send_request(MODE_DELETE,     7'd5,   32'h0000_0000, 1'b1);  // last entry
    send_request(MODE_DELETE,     7'd0,   32'h0000_0000, 1'b1);
    send_request(MODE_POP_FRONT,  7'd0,   32'h0000_0000, 1'b1);
    send_request(MODE_POP_BACK,   7'd0,   32'h0000_0000, 1'b1);
    send_request(MODE_UNUSED,     7'd127, 32'hFFFF_FFFF, 1'b1);  // unused code
    send_request(MODE_DELETE,     7'd64,  32'h0000_0000, 1'b1);

    // Random: alternate growing and shrinking phases; turn around at full or
    // empty after lingering a few requests there to exercise the full/empty paths.
    grow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      n = sb.entry_total();
      if (grow && n == LIST_DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      else if (!grow && n == 0 && $urandom_range(3) == 0) grow = 1'b1;

      mode = pick_mode(grow);
      val  = pick_value();

      // mostly legal positions, some at exactly count, some anywhere in 7 bits
      r = $urandom_range(99);
      if (r < 10 || n == 0) pos = POS_W'($urandom_range(127));
      else if (r < 15) pos = POS_W'(n);
      else if (mode == MODE_DELETE) pos = POS_W'($urandom_range(n - 1));
      else pos = POS_W'($urandom_range(n));

      // half the searches look for a value that is in the list
      if (mode == MODE_SEARCH && n > 0 && $urandom_range(1) == 1) begin
        val = sb.shadow_list[$urandom_range(n - 1)];
      end

      // middle of the run goes back to back, no idle cycles at all
      send_request(mode, pos, val, !(i >= 300 && i < 700));
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // catch any stray strobe after the last result

    $display("Ran %0d requests: %0d pushes, %0d inserts, %0d deletes/pops, %0d searches (%0d hits)",
             sb.results_checked,
             sb.mode_seen[MODE_PUSH_FRONT] + sb.mode_seen[MODE_PUSH_BACK],
             sb.mode_seen[MODE_INSERT],
             sb.mode_seen[MODE_DELETE] + sb.mode_seen[MODE_POP_FRONT]
               + sb.mode_seen[MODE_POP_BACK],
             sb.mode_seen[MODE_SEARCH], sb.search_hits);
    $display("Status seen: ok %0d, out of range %0d, empty %0d, full %0d",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANGE],
             sb.status_seen[STATUS_EMPTY], sb.status_seen[STATUS_FULL]);
    if (sb.errors == 0) begin
      $display("PASS bounded_ordered_list_engine");
    end else begin
      $display("FAIL bounded_ordered_list_engine");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bole_pkg.sv
src/bole_cell.sv
src/bole_genc.sv
src/bounded_ordered_list_engine.sv
src/bole_chk.sv
tb/sv/testbench.sv
